// File: sv/running_median_filter_assert.svh
// Assertion macros used by the checker file rmf_checker.sv.
`ifndef RUNNING_MEDIAN_FILTER_ASSERT_SVH
`define RUNNING_MEDIAN_FILTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RMF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("running_median_filter: assertion failed");

// Next-cycle implication, disabled during reset.
`define RMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("running_median_filter: assertion failed");

`endif

// File: sv/rmf_pkg.sv
package rmf_pkg;

    // Window and sample geometry
    localparam int WINDOW = 15;
    localparam int DATA_W = 32;
    localparam int MID    = WINDOW / 2;
    localparam int BIT_W  = $clog2(DATA_W);
    localparam int CNT_W  = $clog2(WINDOW + 1);

    // Popcount grouping for the zero count
    localparam int GRP    = 8;
    localparam int NGRP   = (WINDOW + GRP - 1) / GRP;

    typedef logic [DATA_W-1:0] word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

endpackage

// File: sv/running_median_filter.sv
// Running median over the last 15 signed 32-bit samples (1/256 m units); the
// window starts as zeros and those zeros count until pushed out. Each sample
// is first shifted into the window; then a bit-serial rank search walks all
// window entries MSB first, one bit per cycle, with a single narrow zero
// count and rank compare. No new sample is taken until that search is done,
// nor while its median waits for a busy output register. A finished median
// waits in an output register, so the next sample is taken while it waits.
module running_median_filter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [rmf_pkg::DATA_W-1:0] sample,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    output logic [rmf_pkg::DATA_W-1:0] median,
    output logic                       median_valid,
    input  logic                       median_stall
);

    rmf_pkg::state_t state_reg, state_next;

    rmf_pkg::word_t win_reg  [rmf_pkg::WINDOW];
    rmf_pkg::word_t win_next [rmf_pkg::WINDOW];

    logic [rmf_pkg::WINDOW-1:0] cand_reg, cand_next;
    logic [rmf_pkg::CNT_W-1:0]  rank_reg, rank_next;
    logic [rmf_pkg::BIT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    rmf_pkg::word_t             acc_reg, acc_next;
    rmf_pkg::word_t             med_reg, med_next;
    logic                       out_valid_reg, out_valid_next;

    // Control decoded from state
    logic do_load;
    logic do_run;
    logic slot_free;
    logic last_bit;
    logic deliver_run;
    logic deliver_hold;

    // Bit-slice datapath
    logic                       first_bit;
    logic [rmf_pkg::WINDOW-1:0] key_vec;
    logic [rmf_pkg::WINDOW-1:0] zero_vec;
    logic [rmf_pkg::CNT_W-1:0]  grp_cnt [rmf_pkg::NGRP];
    logic [rmf_pkg::CNT_W-1:0]  zero_cnt;
    logic                       key_bit;
    logic                       raw_bit;

    assign slot_free = !out_valid_reg || !median_stall;
    assign last_bit  = (bit_cnt_reg == rmf_pkg::BIT_W'(rmf_pkg::DATA_W - 1));
    assign first_bit = (bit_cnt_reg == '0);

    // FSM outputs
    always_comb
    begin
        sample_stall = (state_reg != rmf_pkg::ST_IDLE);
        do_load      = (state_reg == rmf_pkg::ST_IDLE) && sample_valid;
        do_run       = (state_reg == rmf_pkg::ST_RUN);
        deliver_run  = do_run && last_bit && slot_free;
        deliver_hold = (state_reg == rmf_pkg::ST_HOLD) && slot_free;
    end

    // FSM next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rmf_pkg::ST_IDLE:
            begin
                if (sample_valid)
                    state_next = rmf_pkg::ST_RUN;
            end
            rmf_pkg::ST_RUN:
            begin
                if (last_bit)
                    state_next = slot_free ? rmf_pkg::ST_IDLE : rmf_pkg::ST_HOLD;
            end
            rmf_pkg::ST_HOLD:
            begin
                if (slot_free)
                    state_next = rmf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rmf_pkg::ST_IDLE;
            end
        endcase
    end

    // Current key bit of every entry; sign bit inverted for signed order
    always_comb
    begin
        for (int i = 0; i < rmf_pkg::WINDOW; i++)
        begin
            key_vec[i] = win_reg[i][rmf_pkg::DATA_W-1] ^ first_bit;
        end
        zero_vec = cand_reg & ~key_vec;
    end

    // Count candidates with a zero key bit, in groups then across groups
    always_comb
    begin
        for (int g = 0; g < rmf_pkg::NGRP; g++)
        begin
            grp_cnt[g] = '0;
            for (int j = 0; j < rmf_pkg::GRP; j++)
            begin
                if (g * rmf_pkg::GRP + j < rmf_pkg::WINDOW)
                    grp_cnt[g] = grp_cnt[g]
                               + rmf_pkg::CNT_W'(zero_vec[g * rmf_pkg::GRP + j]);
            end
        end
        zero_cnt = '0;
        for (int g = 0; g < rmf_pkg::NGRP; g++)
        begin
            zero_cnt = zero_cnt + grp_cnt[g];
        end
    end

    // Median bit: zero if the target rank lies among the zero-bit candidates
    assign key_bit = !(zero_cnt > rank_reg);
    assign raw_bit = key_bit ^ first_bit;

    // Datapath next values
    always_comb
    begin
        win_next     = win_reg;
        cand_next    = cand_reg;
        rank_next    = rank_reg;
        bit_cnt_next = bit_cnt_reg;
        acc_next     = acc_reg;
        if (do_load)
        begin
            for (int i = 0; i < rmf_pkg::WINDOW - 1; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[rmf_pkg::WINDOW-1] = sample;
            cand_next    = '1;
            rank_next    = rmf_pkg::CNT_W'(rmf_pkg::MID);
            bit_cnt_next = '0;
        end
        else if (do_run)
        begin
            // Rotate every entry; after a full pass the window is unchanged
            for (int i = 0; i < rmf_pkg::WINDOW; i++)
            begin
                win_next[i] = {win_reg[i][rmf_pkg::DATA_W-2:0],
                               win_reg[i][rmf_pkg::DATA_W-1]};
            end
            if (key_bit)
            begin
                cand_next = cand_reg & key_vec;
                rank_next = rank_reg - zero_cnt;
            end
            else
            begin
                cand_next = zero_vec;
            end
            acc_next     = {acc_reg[rmf_pkg::DATA_W-2:0], raw_bit};
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end
    end

    // Output register
    always_comb
    begin
        med_next       = med_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !median_stall)
            out_valid_next = 1'b0;
        if (deliver_run)
        begin
            med_next       = {acc_reg[rmf_pkg::DATA_W-2:0], raw_bit};
            out_valid_next = 1'b1;
        end
        else if (deliver_hold)
        begin
            med_next       = acc_reg;
            out_valid_next = 1'b1;
        end
    end

    // Control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rmf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            cand_reg      <= '0;
            rank_reg      <= '0;
            bit_cnt_reg   <= '0;
            for (int i = 0; i < rmf_pkg::WINDOW; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cand_reg      <= cand_next;
            rank_reg      <= rank_next;
            bit_cnt_reg   <= bit_cnt_next;
            win_reg       <= win_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        med_reg <= med_next;
    end

    assign median       = med_reg;
    assign median_valid = out_valid_reg;

endmodule

// File: sv/rmf_checker.sv
`include "running_median_filter_assert.svh"

module rmf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       sample_valid,
    input logic                       sample_stall,
    input logic [rmf_pkg::DATA_W-1:0] median,
    input logic                       median_valid,
    input logic                       median_stall
);

    // A stalled result stays offered
    `RMF_ASSERT_NEXT(a_out_hold, clk, rst_n, median_valid && median_stall, median_valid)

    // A stalled result keeps its value
    `RMF_ASSERT_NEXT(a_out_stable, clk, rst_n, median_valid && median_stall, $stable(median))

    // Once a sample is taken the block is busy with it
    `RMF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, sample_valid && !sample_stall, sample_stall)

    // A new result only comes out of a busy period
    `RMF_ASSERT_NOW(a_result_from_work, clk, rst_n, $rose(median_valid), $past(sample_stall))

endmodule

bind running_median_filter rmf_checker u_rmf_checker (.*);
